// ----- sv/jexif_pkg.sv -----
package jexif_pkg;

    typedef enum logic [3:0] {
        PH_SOI0,
        PH_SOI1,
        PH_MARK0,
        PH_MARK1,
        PH_SKLEN0,
        PH_SKLEN1,
        PH_SKIP,
        PH_APLEN0,
        PH_APLEN1,
        PH_APDATA,
        PH_DONE
    } t_phase;

    typedef enum logic [2:0] {
        ST_FOUND      = 3'd0,
        ST_TOO_SHORT  = 3'd1,
        ST_NO_SOI     = 3'd2,
        ST_NO_TAG     = 3'd3,
        ST_BAD_MARKER = 3'd4
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        t_status    status;
        logic [8:0] rotation;
    } t_result;

    localparam logic [7:0]  MARKER_PREFIX = 8'hFF;
    localparam logic [7:0]  SOI_CODE      = 8'hD8;
    localparam logic [7:0]  APP1_CODE     = 8'hE1;
    localparam logic [7:0]  ORDER_MM      = 8'h4D;
    localparam logic [15:0] ORIENT_TAG    = 16'h0112;
    localparam logic [3:0]  ENTRY_BYTES   = 4'd12;
    localparam logic [15:0] SIG_LEN       = 16'd6;
    localparam logic [15:0] OFFSET_POS    = 16'd10;
    localparam logic [15:0] ENTRIES_POS   = 16'd14;
    localparam logic [31:0] MIN_IFD_OFF   = 32'd8;

    // "Exif\0\0"
    function automatic logic [7:0] exif_sig(input logic [2:0] idx);
        logic [7:0] v;
        unique case (idx)
            3'd0: v = 8'h45;
            3'd1: v = 8'h78;
            3'd2: v = 8'h69;
            3'd3: v = 8'h66;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [8:0] map_rotation(input logic [15:0] v);
        logic [8:0] r;
        priority if (v == 16'd3) r = 9'd180;
        else if (v == 16'd6) r = 9'd90;
        else if (v == 16'd8) r = 9'd270;
        else r = 9'd0;
        return r;
    endfunction

endpackage

// ----- sv/jexif_in_stage.sv -----
module jexif_in_stage
    import jexif_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_word i_word,
    input  logic     i_take,
    output logic     o_valid,
    output t_in_word o_word
);

    logic     r_valid;
    t_in_word r_word;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= i_word;
        end
    end

endmodule

// ----- sv/jexif_core.sv -----
module jexif_core
    import jexif_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_word i_word,
    input  logic     i_out_space,
    output logic     o_take,
    output logic     o_emit,
    output t_result  o_result
);

    t_phase      r_phase, n_phase;
    logic [15:0] r_pos, n_pos;
    logic [15:0] r_seg, n_seg;
    logic        r_big, n_big;
    logic [31:0] r_off, n_off;
    logic [15:0] r_cnt, n_cnt;
    logic [15:0] r_idx, n_idx;
    logic [3:0]  r_ebc, n_ebc;
    logic [7:0]  r_held, n_held;
    logic        r_tag, n_tag;
    logic [8:0]  r_rot, n_rot;
    logic        r_fv, n_fv;
    logic        r_given, n_given;

    logic [7:0]  b;
    logic        last;
    logic [15:0] w_len;
    logic [15:0] w_join;
    logic [32:0] w_rel;
    logic [1:0]  w_lane;
    logic        emit;
    t_status     status;

    assign b      = i_word.data_byte;
    assign last   = i_word.last_byte;
    assign w_len  = {r_held, b};
    assign w_join = r_big ? {r_held, b} : {b, r_held};
    assign w_rel  = {17'd0, r_pos - SIG_LEN};
    assign w_lane = 2'(r_pos - OFFSET_POS);

    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_seg   = r_seg;
        n_big   = r_big;
        n_off   = r_off;
        n_cnt   = r_cnt;
        n_idx   = r_idx;
        n_ebc   = r_ebc;
        n_held  = r_held;
        n_tag   = r_tag;
        n_rot   = r_rot;
        n_fv    = r_fv;
        n_given = r_given;
        emit    = 1'b0;
        status  = ST_FOUND;

        if (!r_given) begin
            unique case (r_phase)
                PH_SOI0: begin
                    if (last) begin
                        emit = 1'b1; status = ST_TOO_SHORT;
                    end else if (b != MARKER_PREFIX) begin
                        emit = 1'b1; status = ST_NO_SOI;
                    end else begin
                        n_phase = PH_SOI1;
                    end
                end
                PH_SOI1: begin
                    if (b != SOI_CODE) begin
                        emit = 1'b1; status = ST_NO_SOI;
                    end else begin
                        n_phase = PH_MARK0;
                    end
                end
                PH_MARK0: begin
                    if (b != MARKER_PREFIX) begin
                        emit = 1'b1; status = ST_BAD_MARKER;
                    end else begin
                        n_phase = PH_MARK1;
                    end
                end
                PH_MARK1: begin
                    n_phase = (b == APP1_CODE) ? PH_APLEN0 : PH_SKLEN0;
                end
                PH_SKLEN0: begin
                    n_held  = b;
                    n_phase = PH_SKLEN1;
                end
                PH_APLEN0: begin
                    n_held  = b;
                    n_phase = PH_APLEN1;
                end
                PH_SKLEN1: begin
                    n_seg = w_len;
                    priority if (w_len < 16'd2) begin
                        emit = 1'b1; status = ST_BAD_MARKER;
                    end else if (w_len == 16'd2) begin
                        n_phase = PH_MARK0;
                    end else begin
                        n_seg   = w_len - 16'd2;
                        n_phase = PH_SKIP;
                    end
                end
                PH_SKIP: begin
                    n_seg = r_seg - 16'd1;
                    if (r_seg == 16'd1) begin
                        n_phase = PH_MARK0;
                    end
                end
                PH_APLEN1: begin
                    n_seg = w_len;
                    if (w_len <= 16'd2) begin
                        emit = 1'b1; status = ST_NO_TAG;
                    end else begin
                        n_seg   = w_len - 16'd2;
                        n_pos   = 16'd0;
                        n_off   = 32'd0;
                        n_cnt   = 16'd0;
                        n_phase = PH_APDATA;
                    end
                end
                PH_APDATA: begin
                    priority if (r_pos < SIG_LEN) begin
                        if (b != exif_sig(r_pos[2:0])) begin
                            emit = 1'b1; status = ST_NO_TAG;
                        end
                    end else if (r_pos == SIG_LEN) begin
                        n_held = b;
                    end else if (r_pos == SIG_LEN + 16'd1) begin
                        n_big = (r_held == ORDER_MM) && (b == ORDER_MM);
                    end else if (r_pos < OFFSET_POS) begin
                        n_off = r_off;
                    end else if (r_pos < ENTRIES_POS) begin
                        if (r_big) begin
                            n_off = {r_off[23:0], b};
                        end else begin
                            unique case (w_lane)
                                2'd0: n_off = r_off | {24'd0, b};
                                2'd1: n_off = r_off | {16'd0, b, 8'd0};
                                2'd2: n_off = r_off | {8'd0, b, 16'd0};
                                default: n_off = r_off | {b, 24'd0};
                            endcase
                        end
                    end else if (r_off < MIN_IFD_OFF) begin
                        n_off = r_off;
                    end else if (w_rel < {1'b0, r_off}) begin
                        n_off = r_off;
                    end else if (w_rel == {1'b0, r_off}) begin
                        n_held = b;
                    end else if (w_rel == {1'b0, r_off} + 33'd1) begin
                        n_cnt = w_join;
                        n_idx = 16'd0;
                        n_ebc = 4'd0;
                    end else if (r_idx < r_cnt) begin
                        if (r_ebc == 4'd0 || r_ebc == 4'd8) begin
                            n_held = b;
                        end else if (r_ebc == 4'd1) begin
                            n_tag = (w_join == ORIENT_TAG);
                        end else if (r_ebc == 4'd9 && r_tag) begin
                            n_rot = map_rotation(w_join);
                            n_fv  = 1'b1;
                        end
                        if (r_ebc == ENTRY_BYTES - 4'd1) begin
                            n_ebc = 4'd0;
                            n_idx = r_idx + 16'd1;
                        end else begin
                            n_ebc = r_ebc + 4'd1;
                        end
                    end
                    if (!emit) begin
                        n_pos = r_pos + 16'd1;
                        n_seg = r_seg - 16'd1;
                        if (r_seg == 16'd1) begin
                            emit   = 1'b1;
                            status = n_fv ? ST_FOUND : ST_NO_TAG;
                        end
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase

            // end of file before a verdict
            if (!emit && last) begin
                emit = 1'b1;
                priority if (n_phase == PH_APLEN0 || n_phase == PH_APLEN1) begin
                    status = ST_NO_TAG;
                end else if (n_phase == PH_APDATA) begin
                    status = n_fv ? ST_FOUND : ST_NO_TAG;
                end else begin
                    status = ST_BAD_MARKER;
                end
            end

            if (emit) begin
                n_given = 1'b1;
                n_phase = PH_DONE;
            end
        end

        o_result.status   = status;
        o_result.rotation = (status == ST_FOUND) ? n_rot : 9'd0;

        // next file starts from scratch
        if (last) begin
            n_phase = PH_SOI0;
            n_pos   = 16'd0;
            n_seg   = 16'd0;
            n_big   = 1'b0;
            n_off   = 32'd0;
            n_cnt   = 16'd0;
            n_idx   = 16'd0;
            n_ebc   = 4'd0;
            n_held  = 8'd0;
            n_tag   = 1'b0;
            n_rot   = 9'd0;
            n_fv    = 1'b0;
            n_given = 1'b0;
        end
    end

    assign o_take = i_valid && (!emit || i_out_space);
    assign o_emit = o_take && emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SOI0;
            r_pos   <= 16'd0;
            r_seg   <= 16'd0;
            r_big   <= 1'b0;
            r_off   <= 32'd0;
            r_cnt   <= 16'd0;
            r_idx   <= 16'd0;
            r_ebc   <= 4'd0;
            r_held  <= 8'd0;
            r_tag   <= 1'b0;
            r_rot   <= 9'd0;
            r_fv    <= 1'b0;
            r_given <= 1'b0;
        end else if (o_take) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_seg   <= n_seg;
            r_big   <= n_big;
            r_off   <= n_off;
            r_cnt   <= n_cnt;
            r_idx   <= n_idx;
            r_ebc   <= n_ebc;
            r_held  <= n_held;
            r_tag   <= n_tag;
            r_rot   <= n_rot;
            r_fv    <= n_fv;
            r_given <= n_given;
        end
    end

    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && last) |=> (r_phase == PH_SOI0 && !r_given && !r_fv))
        else $error("parser did not restart after last word");

    a_one_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_emit && !last) |=> (r_given && r_phase == PH_DONE))
        else $error("verdict given but parser still active");

    a_given_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_given && i_valid) |-> !emit)
        else $error("second verdict in one file");

endmodule

// ----- sv/jexif_out_stage.sv -----
module jexif_out_stage
    import jexif_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_ready,
    output logic    o_space,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_space  = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_space) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    a_rot_only_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_result.rotation != 9'd0) |-> (r_result.status == ST_FOUND))
        else $error("rotation reported without a found tag");

endmodule

// ----- sv/jpeg_exif_orientation_parser_top.sv -----
// EXIF orientation extractor for a JPEG byte stream.
// Input channel: one file byte per word on i_data_byte, i_last_byte marks the
// final byte of a file. Output channel: one status word per file with
// o_status (0 found, 1 too short, 2 no SOI, 3 APP1 lacks tag, 4 bad marker or
// end) and o_rotation_degrees (0, 90, 180 or 270, zero unless found).
// A word is taken whenever valid and ready are both high.
// Throughput: one byte per cycle unless a verdict waits on a full result
// register; the whole state update for a byte is combinational in the parser
// core between the input and result registers; the status word is held in the
// result register behind o_out_valid. Bytes after the verdict are consumed and
// dropped up to the last byte, which restarts the parser for the next file.
// Reset empties both registers and puts the parser at the start of a file.
// When the receiver stalls, the status word holds, bytes that give no verdict
// keep flowing, and the input stalls only when a second verdict is due.
module jpeg_exif_orientation_parser_top
    import jexif_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [2:0] o_status,
    output logic [8:0] o_rotation_degrees
);

    t_in_word w_in_word;
    t_in_word w_core_word;
    logic     w_core_valid;
    logic     w_take;
    logic     w_emit;
    logic     w_space;
    t_result  w_core_result;
    t_result  w_out_result;

    assign w_in_word.data_byte = i_data_byte;
    assign w_in_word.last_byte = i_last_byte;

    jexif_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_word  (w_in_word),
        .i_take  (w_take),
        .o_valid (w_core_valid),
        .o_word  (w_core_word)
    );

    jexif_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_core_valid),
        .i_word      (w_core_word),
        .i_out_space (w_space),
        .o_take      (w_take),
        .o_emit      (w_emit),
        .o_result    (w_core_result)
    );

    jexif_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_emit),
        .i_result (w_core_result),
        .i_ready  (i_out_ready),
        .o_space  (w_space),
        .o_valid  (o_out_valid),
        .o_result (w_out_result)
    );

    assign o_status           = w_out_result.status;
    assign o_rotation_degrees = w_out_result.rotation;

endmodule

// ----- verif/jexif_orientation_checker.sv -----
`timescale 1ns / 100ps
module jexif_orientation_checker
    import jexif_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [2:0] i_status,
    input  logic [8:0] i_rotation_degrees,
    output int         o_fail_count,
    output int         o_pending
);

    localparam logic [47:0] EXIF_HDR = 48'h457869660000;

    // parser state mirror
    t_phase      phase;
    logic [15:0] app_pos;
    logic [15:0] seg_left;
    bit          order_big;
    logic [31:0] ifd_off;
    logic [15:0] n_entries;
    logic [15:0] entry_idx;
    logic [3:0]  entry_byte;
    logic [7:0]  held;
    bit          tag_hit;
    logic [8:0]  rotation_seen;
    bit          rotation_valid;
    bit          verdict_out;

    t_result     status_due[$];
    int          fails = 0;

    function automatic logic [15:0] pair16(input logic [7:0] first, input logic [7:0] second);
        return order_big ? {first, second} : {second, first};
    endfunction

    function automatic logic [8:0] orient_to_degrees(input logic [15:0] v);
        case (v)
            16'd3:   return 9'd180;
            16'd6:   return 9'd90;
            16'd8:   return 9'd270;
            default: return 9'd0;
        endcase
    endfunction

    task automatic clear_parser();
        phase          = PH_SOI0;
        app_pos        = '0;
        seg_left       = '0;
        order_big      = 1'b0;
        ifd_off        = '0;
        n_entries      = '0;
        entry_idx      = '0;
        entry_byte     = '0;
        held           = '0;
        tag_hit        = 1'b0;
        rotation_seen  = '0;
        rotation_valid = 1'b0;
        verdict_out    = 1'b0;
    endtask

    // one byte of APP1 payload, position app_pos
    task automatic parse_exif_byte(input logic [7:0] b, output bit header_bad);
        logic [15:0] d;
        logic [32:0] rel;
        logic [32:0] off_ext;
        d = app_pos;
        header_bad = 1'b0;
        rel = 33'(d) - 33'd6;
        off_ext = {1'b0, ifd_off};
        if (d < SIG_LEN) begin
            header_bad = (b != EXIF_HDR[47 - 8 * d -: 8]);
        end else if (d == 16'd6) begin
            held = b;
        end else if (d == 16'd7) begin
            order_big = (held == ORDER_MM) && (b == ORDER_MM);
        end else if (d < OFFSET_POS) begin
            // tiff magic, not checked
        end else if (d < ENTRIES_POS) begin
            if (order_big) begin
                ifd_off = {ifd_off[23:0], b};
            end else begin
                ifd_off = ifd_off | (32'(b) << ((d - OFFSET_POS) * 8));
            end
        end else if (ifd_off >= MIN_IFD_OFF) begin
            if (rel < off_ext) begin
                // before the directory
            end else if (rel == off_ext) begin
                held = b;
            end else if (rel == off_ext + 33'd1) begin
                n_entries  = pair16(held, b);
                entry_idx  = '0;
                entry_byte = '0;
            end else if (entry_idx < n_entries) begin
                if (entry_byte == 4'd0 || entry_byte == 4'd8) begin
                    held = b;
                end else if (entry_byte == 4'd1) begin
                    tag_hit = (pair16(held, b) == ORIENT_TAG);
                end else if (entry_byte == 4'd9 && tag_hit) begin
                    rotation_seen  = orient_to_degrees(pair16(held, b));
                    rotation_valid = 1'b1;
                end
                entry_byte = entry_byte + 4'd1;
                if (entry_byte >= ENTRY_BYTES) begin
                    entry_byte = '0;
                    entry_idx  = entry_idx + 16'd1;
                end
            end
        end
    endtask

    task automatic parse_file_byte(input logic [7:0] b, input bit last);
        bit      decided;
        bit      header_bad;
        t_status st;
        t_result exp_word;
        decided = 1'b0;
        st = ST_FOUND;
        if (!verdict_out) begin
            case (phase)
                PH_SOI0: begin
                    if (last) begin
                        decided = 1'b1;
                        st = ST_TOO_SHORT;
                    end else if (b != MARKER_PREFIX) begin
                        decided = 1'b1;
                        st = ST_NO_SOI;
                    end else begin
                        phase = PH_SOI1;
                    end
                end
                PH_SOI1: begin
                    if (b != SOI_CODE) begin
                        decided = 1'b1;
                        st = ST_NO_SOI;
                    end else begin
                        phase = PH_MARK0;
                    end
                end
                PH_MARK0: begin
                    if (b != MARKER_PREFIX) begin
                        decided = 1'b1;
                        st = ST_BAD_MARKER;
                    end else begin
                        phase = PH_MARK1;
                    end
                end
                PH_MARK1: begin
                    phase = (b == APP1_CODE) ? PH_APLEN0 : PH_SKLEN0;
                end
                PH_SKLEN0: begin
                    held = b;
                    phase = PH_SKLEN1;
                end
                PH_APLEN0: begin
                    held = b;
                    phase = PH_APLEN1;
                end
                PH_SKLEN1: begin
                    seg_left = {held, b};
                    if (seg_left < 16'd2) begin
                        decided = 1'b1;
                        st = ST_BAD_MARKER;
                    end else if (seg_left == 16'd2) begin
                        phase = PH_MARK0;
                    end else begin
                        seg_left = seg_left - 16'd2;
                        phase = PH_SKIP;
                    end
                end
                PH_SKIP: begin
                    seg_left = seg_left - 16'd1;
                    if (seg_left == 16'd0) begin
                        phase = PH_MARK0;
                    end
                end
                PH_APLEN1: begin
                    seg_left = {held, b};
                    if (seg_left <= 16'd2) begin
                        decided = 1'b1;
                        st = ST_NO_TAG;
                    end else begin
                        seg_left  = seg_left - 16'd2;
                        app_pos   = '0;
                        ifd_off   = '0;
                        n_entries = '0;
                        phase     = PH_APDATA;
                    end
                end
                PH_APDATA: begin
                    parse_exif_byte(b, header_bad);
                    if (header_bad) begin
                        decided = 1'b1;
                        st = ST_NO_TAG;
                    end else begin
                        app_pos  = app_pos + 16'd1;
                        seg_left = seg_left - 16'd1;
                        if (seg_left == 16'd0) begin
                            decided = 1'b1;
                            st = rotation_valid ? ST_FOUND : ST_NO_TAG;
                        end
                    end
                end
                default: begin
                end
            endcase
            if (!decided && last) begin
                decided = 1'b1;
                if (phase == PH_APLEN0 || phase == PH_APLEN1) begin
                    st = ST_NO_TAG;
                end else if (phase == PH_APDATA) begin
                    st = rotation_valid ? ST_FOUND : ST_NO_TAG;
                end else begin
                    st = ST_BAD_MARKER;
                end
            end
            if (decided) begin
                exp_word.status   = st;
                exp_word.rotation = (st == ST_FOUND) ? rotation_seen : 9'd0;
                status_due.push_back(exp_word);
                verdict_out = 1'b1;
                phase = PH_DONE;
            end
        end
        // last byte restarts for the next file
        if (last) begin
            clear_parser();
        end
    endtask

    always @(posedge i_clk) begin
        t_result got_exp;
        if (!i_rst_n) begin
            clear_parser();
            status_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (status_due.size() == 0) begin
                    $error("unexpected status word: status %0d rotation %0d",
                           i_status, i_rotation_degrees);
                    fails++;
                end else begin
                    got_exp = status_due.pop_front();
                    if (i_status !== got_exp.status) begin
                        $error("status: expected %0d, got %0d", got_exp.status, i_status);
                        fails++;
                    end
                    if (i_rotation_degrees !== got_exp.rotation) begin
                        $error("rotation_degrees: expected %0d, got %0d",
                               got_exp.rotation, i_rotation_degrees);
                        fails++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                parse_file_byte(i_data_byte, i_last_byte);
            end
        end
        o_pending    <= status_due.size();
        o_fail_count <= fails;
    end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
module testbench;
    import jexif_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic [7:0] i_data_byte = 8'h00;
    logic       i_last_byte = 1'b0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic [2:0] o_status;
    logic [8:0] o_rotation_degrees;

    int fail_count;
    int pending;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_req = 1'b0;
    bit hold_taken = 1'b0;
    int hold_left = 0;
    int stall_cycles = 0;
    int bytes_sent = 0;

    logic [7:0] jpeg_bytes[$];

    // short files for the early-exit cases
    logic [7:0] dir_bytes [30] = '{
        8'h00,
        8'h12, 8'h34,
        8'hFF, 8'h00,
        8'hFF, 8'hD8,
        8'hFF, 8'hD8, 8'h00, 8'hFF,
        8'hFF, 8'hD8, 8'hFF, 8'hC0, 8'h00, 8'h01, 8'hFF,
        8'hFF, 8'hD8, 8'hFF, 8'hE1, 8'h00,
        8'hFF, 8'hD8, 8'hFF, 8'hE1, 8'h00, 8'h02, 8'h00
    };
    int dir_sizes [8] = '{1, 2, 2, 2, 4, 7, 5, 7};

    always #5 i_clk = ~i_clk;

    jpeg_exif_orientation_parser_top u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_data_byte        (i_data_byte),
        .i_last_byte        (i_last_byte),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_status           (o_status),
        .o_rotation_degrees (o_rotation_degrees)
    );

    jexif_orientation_checker u_check (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .i_in_ready         (o_in_ready),
        .i_data_byte        (i_data_byte),
        .i_last_byte        (i_last_byte),
        .i_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .i_status           (o_status),
        .i_rotation_degrees (o_rotation_degrees),
        .o_fail_count       (fail_count),
        .o_pending          (pending)
    );

    // receiver, with one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            i_out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic add_half(input logic [15:0] v, input bit big);
        if (big) begin
            jpeg_bytes.push_back(v[15:8]);
            jpeg_bytes.push_back(v[7:0]);
        end else begin
            jpeg_bytes.push_back(v[7:0]);
            jpeg_bytes.push_back(v[15:8]);
        end
    endtask

    task automatic build_jpeg_file();
        int          kind;
        int          nseg;
        int          plen;
        int          pad;
        int          nent;
        int          len_at;
        int          body_at;
        int          body_len;
        int          cut;
        logic [15:0] app_len;
        logic [15:0] val;
        logic [31:0] ifd;
        logic [7:0]  mk;
        logic [7:0]  o0;
        logic [7:0]  o1;
        bit          big;
        jpeg_bytes.delete();
        kind = $urandom_range(0, 19);
        if (kind == 0) begin
            repeat ($urandom_range(1, 10)) jpeg_bytes.push_back(8'($urandom));
            return;
        end
        jpeg_bytes.push_back(MARKER_PREFIX);
        jpeg_bytes.push_back(SOI_CODE);
        if (kind == 1) begin
            jpeg_bytes[$urandom_range(0, 1)] = 8'($urandom);
        end
        nseg = (kind == 4) ? 1 : $urandom_range(0, 2);
        repeat (nseg) begin
            jpeg_bytes.push_back((kind == 2) ? 8'($urandom) : MARKER_PREFIX);
            case ($urandom_range(0, 3))
                0: mk = MARKER_PREFIX;
                1: mk = 8'hE0;
                2: mk = 8'hDB;
                default: mk = 8'($urandom);
            endcase
            if (mk == APP1_CODE) begin
                mk = 8'hE2;
            end
            jpeg_bytes.push_back(mk);
            plen = (kind == 4) ? $urandom_range(254, 300) : $urandom_range(0, 5);
            add_half((kind == 3) ? 16'($urandom_range(0, 1)) : 16'(plen + 2), 1'b1);
            repeat (plen) jpeg_bytes.push_back(8'($urandom));
        end
        jpeg_bytes.push_back(MARKER_PREFIX);
        jpeg_bytes.push_back(APP1_CODE);
        len_at = jpeg_bytes.size();
        jpeg_bytes.push_back(8'h00);
        jpeg_bytes.push_back(8'h00);
        body_at = jpeg_bytes.size();
        for (int i = 0; i < 6; i++) begin
            jpeg_bytes.push_back(8'h00);
        end
        jpeg_bytes[body_at]     = 8'h45;
        jpeg_bytes[body_at + 1] = 8'h78;
        jpeg_bytes[body_at + 2] = 8'h69;
        jpeg_bytes[body_at + 3] = 8'h66;
        if (kind == 5) begin
            cut = body_at + $urandom_range(0, 5);
            jpeg_bytes[cut] = jpeg_bytes[cut] ^ 8'($urandom_range(1, 255));
        end
        big = 1'($urandom_range(0, 1));
        o0 = big ? ORDER_MM : 8'h49;
        o1 = o0;
        if (kind == 6) begin
            o0 = $urandom_range(0, 1) ? ORDER_MM : 8'($urandom);
            o1 = $urandom_range(0, 1) ? ORDER_MM : 8'($urandom);
            big = (o0 == ORDER_MM) && (o1 == ORDER_MM);
        end
        jpeg_bytes.push_back(o0);
        jpeg_bytes.push_back(o1);
        jpeg_bytes.push_back(8'($urandom));
        jpeg_bytes.push_back(8'($urandom));
        pad = $urandom_range(0, 3);
        ifd = 32'(8 + pad);
        if (kind == 7) begin
            ifd = $urandom_range(0, 7);
        end else if (kind == 8) begin
            ifd = $urandom_range(0, 1) ? $urandom : $urandom_range(60, 70000);
        end
        add_half(big ? ifd[31:16] : ifd[15:0], big);
        add_half(big ? ifd[15:0] : ifd[31:16], big);
        repeat (pad) jpeg_bytes.push_back(8'($urandom));
        nent = $urandom_range(0, 3);
        add_half((kind == 9) ? 16'($urandom) : 16'(nent), big);
        repeat (nent) begin
            add_half(($urandom_range(0, 2) != 0) ? ORIENT_TAG : 16'($urandom), big);
            repeat (6) jpeg_bytes.push_back(8'($urandom));
            case ($urandom_range(0, 4))
                0: val = 16'd3;
                1: val = 16'd6;
                2: val = 16'd8;
                3: val = 16'($urandom_range(0, 9));
                default: val = 16'($urandom);
            endcase
            add_half(val, big);
            repeat (2) jpeg_bytes.push_back(8'($urandom));
        end
        repeat ($urandom_range(0, 3)) jpeg_bytes.push_back(8'($urandom));
        body_len = jpeg_bytes.size() - body_at;
        app_len = 16'(body_len + 2);
        if (kind == 10) begin
            app_len = 16'($urandom_range(0, 2));
        end else if (kind == 11) begin
            app_len = 16'($urandom_range(3, body_len + 1));
        end
        jpeg_bytes[len_at]     = app_len[15:8];
        jpeg_bytes[len_at + 1] = app_len[7:0];
        repeat ($urandom_range(0, 3)) jpeg_bytes.push_back(8'($urandom));
        if (kind == 12) begin
            cut = $urandom_range(1, jpeg_bytes.size());
            while (jpeg_bytes.size() > cut) void'(jpeg_bytes.pop_back());
        end
    endtask

    // each byte is one word; valid holds until the word is taken
    task automatic send_file();
        for (int i = 0; i < jpeg_bytes.size(); i++) begin
            i_in_valid  <= 1'b1;
            i_data_byte <= jpeg_bytes[i];
            i_last_byte <= (i == jpeg_bytes.size() - 1);
            @(posedge i_clk);
            while (!o_in_ready) @(posedge i_clk);
            bytes_sent++;
            if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
                i_in_valid <= 1'b0;
                do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
            end
        end
    endtask

    initial begin
        int base;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 28;
        recv_idle_pct = 86;
        base = 0;
        foreach (dir_sizes[f]) begin
            jpeg_bytes.delete();
            for (int i = 0; i < dir_sizes[f]; i++) begin
                jpeg_bytes.push_back(dir_bytes[base + i]);
            end
            base += dir_sizes[f];
            send_file();
        end
        while (bytes_sent < 600) begin
            build_jpeg_file();
            send_file();
        end

        send_idle_pct = 86;
        recv_idle_pct = 28;
        while (bytes_sent < 1200) begin
            build_jpeg_file();
            send_file();
        end

        // free running, with one long receiver stall to back up the input
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 1'b1;
        while (bytes_sent < 1800) begin
            build_jpeg_file();
            send_file();
        end
        i_in_valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
